FILE: hdl/tst_pkg.sv
// Shared types, codes and widths for the task state tracker.
// No dependencies; every other file in hdl/ uses this package.
package tst_pkg;

  localparam int EventW   = 5;
  localparam int StateW   = 3;
  localparam int StatusW  = 2;
  localparam int SourceW  = 2;
  localparam int ApbDataW = 32;
  localparam int ApbAddrW = 3;

  // paddr[2] picks the 32-bit register slot; only slot 0 exists
  localparam logic CfgSelInitial = 1'b0;

  typedef enum logic [EventW-1:0] {
    EV_ACTIVATE            = 5'd0,
    EV_START               = 5'd1,
    EV_PREEMPT             = 5'd2,
    EV_RESUME              = 5'd3,
    EV_TERMINATE           = 5'd4,
    EV_POLL                = 5'd5,
    EV_RUN                 = 5'd6,
    EV_PARK                = 5'd7,
    EV_POLL_PARKING        = 5'd8,
    EV_RELEASE_PARKING     = 5'd9,
    EV_WAIT                = 5'd10,
    EV_RELEASE             = 5'd11,
    EV_FULL_MIGRATION      = 5'd12,
    EV_ENFORCED_MIGRATION  = 5'd13,
    EV_INTERRUPT_SUSPENDED = 5'd14,
    EV_MTA_LIMIT           = 5'd15,
    EV_NOWAIT              = 5'd16,
    EV_UNKNOWN             = 5'd17
  } ev_code_t;

  typedef enum logic [StatusW-1:0] {
    STS_OK      = 2'd0,
    STS_ALREADY = 2'd1,
    STS_INVALID = 2'd2
  } status_t;

  typedef enum logic [SourceW-1:0] {
    SRC_STIMULUS  = 2'd0,
    SRC_SCHEDULER = 2'd1,
    SRC_CORE      = 2'd2,
    SRC_NONE      = 2'd3
  } source_t;

  // Encoded state as seen on the ports and the config register
  typedef enum logic [StateW-1:0] {
    SC_RUNNING    = 3'd0,
    SC_POLLING    = 3'd1,
    SC_WAITING    = 3'd2,
    SC_PARKING    = 3'd3,
    SC_READY      = 3'd4,
    SC_ACTIVE     = 3'd5,
    SC_TERMINATED = 3'd6,
    SC_UNKNOWN    = 3'd7
  } state_code_t;

  // Internal one-hot life-cycle state
  typedef enum logic [7:0] {
    LS_RUNNING    = 8'b0000_0001,
    LS_POLLING    = 8'b0000_0010,
    LS_WAITING    = 8'b0000_0100,
    LS_PARKING    = 8'b0000_1000,
    LS_READY      = 8'b0001_0000,
    LS_ACTIVE     = 8'b0010_0000,
    LS_TERMINATED = 8'b0100_0000,
    LS_UNKNOWN    = 8'b1000_0000
  } life_t;

  function automatic life_t life_decode(logic [StateW-1:0] code);
    life_t ls;
    case (code)
      SC_RUNNING:    ls = LS_RUNNING;
      SC_POLLING:    ls = LS_POLLING;
      SC_WAITING:    ls = LS_WAITING;
      SC_PARKING:    ls = LS_PARKING;
      SC_READY:      ls = LS_READY;
      SC_ACTIVE:     ls = LS_ACTIVE;
      SC_TERMINATED: ls = LS_TERMINATED;
      default:       ls = LS_UNKNOWN;
    endcase
    return ls;
  endfunction

  function automatic logic [StateW-1:0] life_encode(life_t ls);
    logic [StateW-1:0] code;
    case (ls)
      LS_RUNNING:    code = SC_RUNNING;
      LS_POLLING:    code = SC_POLLING;
      LS_WAITING:    code = SC_WAITING;
      LS_PARKING:    code = SC_PARKING;
      LS_READY:      code = SC_READY;
      LS_ACTIVE:     code = SC_ACTIVE;
      LS_TERMINATED: code = SC_TERMINATED;
      default:       code = SC_UNKNOWN;
    endcase
    return code;
  endfunction

endpackage

FILE: hdl/tst_ifs.sv
// Valid/ready channel interfaces for trace events and tracker results.
// Depends on tst_pkg for field widths.
interface tst_evt_if;
  logic                         valid;
  logic                         ready;
  logic [tst_pkg::EventW-1:0]   event_code;

  modport source (output valid, output event_code, input ready);
  modport sink   (input valid, input event_code, output ready);
endinterface

interface tst_res_if;
  logic                         valid;
  logic                         ready;
  logic [tst_pkg::StatusW-1:0]  status;
  logic [tst_pkg::StateW-1:0]   new_state;
  logic                         started_seen;
  logic                         is_terminated;
  logic [tst_pkg::SourceW-1:0]  source_kind;
  logic                         takes_core;
  logic                         frees_core;

  modport source (output valid, output status, output new_state, output started_seen,
                  output is_terminated, output source_kind, output takes_core,
                  output frees_core, input ready);
  modport sink   (input valid, input status, input new_state, input started_seen,
                  input is_terminated, input source_kind, input takes_core,
                  input frees_core, output ready);
endinterface

FILE: hdl/task_state_tracker_core.sv
// Top level of the task life-cycle state tracker.
// Depends on tst_pkg and the channel interfaces in tst_ifs.sv.
//
//  channel   | dir | handshake          | carries
//  ----------+-----+--------------------+---------------------------------------
//  events    | in  | valid/ready        | event_code
//  results   | out | valid/ready        | status, new_state, flags, decode
//  apb       | in  | psel/penable/pready| initial_state register at offset 0
//
// One event per cycle unless the output stalls: an accepted event is decoded
// against the stored state in the same cycle; its result is registered next edge.
// The state register is the only loop, so back-to-back events chain without gaps.
// rst (synchronous) clears the state to unknown, the started flag and the
// output valid. events.ready drops only while a result sits unclaimed in the
// output register and results.ready is low; nothing else stalls the input.
module task_state_tracker_core (
  input  logic                          clk,
  input  logic                          rst,
  tst_evt_if.sink                       events,
  tst_res_if.source                     results,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tst_pkg::ApbAddrW-1:0]  paddr,
  input  logic [tst_pkg::ApbDataW-1:0]  pwdata,
  output logic [tst_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);

  // Stored state
  tst_pkg::life_t                life_state;
  logic                          started_flag;
  logic [tst_pkg::StateW-1:0]    initial_state;

  // Output register
  logic                          out_valid;
  logic [tst_pkg::StatusW-1:0]   out_status;
  logic [tst_pkg::StateW-1:0]    out_state;
  logic                          out_started;
  logic                          out_term;
  logic [tst_pkg::SourceW-1:0]   out_source;
  logic                          out_takes;
  logic                          out_frees;

  // Decode
  tst_pkg::ev_code_t             ev;
  tst_pkg::life_t                life_state_next;
  logic                          started_flag_next;
  tst_pkg::status_t              status;
  tst_pkg::source_t              source;
  logic                          takes;
  logic                          frees;
  logic                          in_xfer;
  logic                          cfg_wr;

  assign pready  = 1'b1;
  assign prdata  = tst_pkg::ApbDataW'(initial_state);
  assign cfg_wr  = psel & penable & pwrite & (paddr[2] == tst_pkg::CfgSelInitial);

  // Input is taken whenever the output register is free or being drained
  assign events.ready = !out_valid || results.ready;
  assign in_xfer      = events.valid && events.ready;

  // Codes past the last named event all behave as the unknown event
  assign ev = (events.event_code >= tst_pkg::EV_UNKNOWN) ? tst_pkg::EV_UNKNOWN
                                                          : tst_pkg::ev_code_t'(events.event_code);

  always_comb begin
    life_state_next   = life_state;
    started_flag_next = started_flag;
    status            = tst_pkg::STS_OK;
    case (life_state)
      tst_pkg::LS_RUNNING: begin
        case (ev)
          tst_pkg::EV_WAIT:      life_state_next = tst_pkg::LS_WAITING;
          tst_pkg::EV_POLL:      life_state_next = tst_pkg::LS_POLLING;
          tst_pkg::EV_PREEMPT:   life_state_next = tst_pkg::LS_READY;
          tst_pkg::EV_TERMINATE: life_state_next = tst_pkg::LS_TERMINATED;
          tst_pkg::EV_NOWAIT:    life_state_next = tst_pkg::LS_RUNNING;
          tst_pkg::EV_START,
          tst_pkg::EV_RESUME,
          tst_pkg::EV_RUN:       status = tst_pkg::STS_ALREADY;
          default:               status = tst_pkg::STS_INVALID;
        endcase
      end
      tst_pkg::LS_POLLING: begin
        case (ev)
          tst_pkg::EV_RUN:          life_state_next = tst_pkg::LS_RUNNING;
          tst_pkg::EV_PARK:         life_state_next = tst_pkg::LS_PARKING;
          tst_pkg::EV_POLL_PARKING,
          tst_pkg::EV_POLL:         status = tst_pkg::STS_ALREADY;
          default:                  status = tst_pkg::STS_INVALID;
        endcase
      end
      tst_pkg::LS_WAITING: begin
        case (ev)
          tst_pkg::EV_RELEASE: life_state_next = tst_pkg::LS_READY;
          tst_pkg::EV_WAIT:    status = tst_pkg::STS_ALREADY;
          default:             status = tst_pkg::STS_INVALID;
        endcase
      end
      tst_pkg::LS_PARKING: begin
        case (ev)
          tst_pkg::EV_POLL_PARKING:    life_state_next = tst_pkg::LS_POLLING;
          tst_pkg::EV_RELEASE_PARKING: life_state_next = tst_pkg::LS_READY;
          tst_pkg::EV_PARK:            status = tst_pkg::STS_ALREADY;
          default:                     status = tst_pkg::STS_INVALID;
        endcase
      end
      tst_pkg::LS_READY: begin
        case (ev)
          tst_pkg::EV_RESUME:          life_state_next = tst_pkg::LS_RUNNING;
          tst_pkg::EV_PREEMPT,
          tst_pkg::EV_RELEASE,
          tst_pkg::EV_RELEASE_PARKING: status = tst_pkg::STS_ALREADY;
          default:                     status = tst_pkg::STS_INVALID;
        endcase
      end
      tst_pkg::LS_ACTIVE: begin
        case (ev)
          tst_pkg::EV_START: begin
            life_state_next   = tst_pkg::LS_RUNNING;
            started_flag_next = 1'b1;
          end
          tst_pkg::EV_INTERRUPT_SUSPENDED: life_state_next = tst_pkg::LS_ACTIVE;
          tst_pkg::EV_ACTIVATE:            status = tst_pkg::STS_ALREADY;
          default:                         status = tst_pkg::STS_INVALID;
        endcase
      end
      tst_pkg::LS_TERMINATED: begin
        case (ev)
          tst_pkg::EV_ACTIVATE:  life_state_next = tst_pkg::LS_ACTIVE;
          tst_pkg::EV_MTA_LIMIT: life_state_next = tst_pkg::LS_TERMINATED;
          tst_pkg::EV_TERMINATE: status = tst_pkg::STS_ALREADY;
          default:               status = tst_pkg::STS_INVALID;
        endcase
      end
      default: begin
        // Unknown state: every listed event jumps to its implied state;
        // anything else, the unknown event included, keeps the state.
        case (ev)
          tst_pkg::EV_ACTIVATE,
          tst_pkg::EV_MTA_LIMIT:       life_state_next = tst_pkg::LS_ACTIVE;
          tst_pkg::EV_START: begin
            life_state_next   = tst_pkg::LS_RUNNING;
            started_flag_next = 1'b1;
          end
          tst_pkg::EV_RESUME,
          tst_pkg::EV_RUN:             life_state_next = tst_pkg::LS_RUNNING;
          tst_pkg::EV_POLL,
          tst_pkg::EV_POLL_PARKING:    life_state_next = tst_pkg::LS_POLLING;
          tst_pkg::EV_PARK:            life_state_next = tst_pkg::LS_PARKING;
          tst_pkg::EV_RELEASE_PARKING,
          tst_pkg::EV_PREEMPT,
          tst_pkg::EV_RELEASE:         life_state_next = tst_pkg::LS_READY;
          tst_pkg::EV_WAIT:            life_state_next = tst_pkg::LS_WAITING;
          tst_pkg::EV_TERMINATE:       life_state_next = tst_pkg::LS_TERMINATED;
          default:                     life_state_next = life_state;
        endcase
      end
    endcase
  end

  // Pure event classification, independent of state
  always_comb begin
    case (ev)
      tst_pkg::EV_ACTIVATE,
      tst_pkg::EV_MTA_LIMIT:           source = tst_pkg::SRC_STIMULUS;
      tst_pkg::EV_INTERRUPT_SUSPENDED: source = tst_pkg::SRC_SCHEDULER;
      tst_pkg::EV_UNKNOWN:             source = tst_pkg::SRC_NONE;
      default:                         source = tst_pkg::SRC_CORE;
    endcase
    takes = (ev == tst_pkg::EV_POLL_PARKING) || (ev == tst_pkg::EV_RESUME) ||
            (ev == tst_pkg::EV_START);
    frees = (ev == tst_pkg::EV_PARK) || (ev == tst_pkg::EV_WAIT) ||
            (ev == tst_pkg::EV_TERMINATE) || (ev == tst_pkg::EV_PREEMPT);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      life_state    <= tst_pkg::LS_UNKNOWN;
      started_flag  <= 1'b0;
      initial_state <= tst_pkg::SC_UNKNOWN;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        // Register write reloads the state; the started flag is left alone
        initial_state <= pwdata[tst_pkg::StateW-1:0];
        life_state    <= tst_pkg::life_decode(pwdata[tst_pkg::StateW-1:0]);
      end else if (in_xfer) begin
        life_state    <= life_state_next;
        started_flag  <= started_flag_next;
      end
      if (in_xfer) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_status  <= status;
      out_state   <= tst_pkg::life_encode(life_state_next);
      out_started <= started_flag_next;
      out_term    <= (life_state_next == tst_pkg::LS_TERMINATED);
      out_source  <= source;
      out_takes   <= takes;
      out_frees   <= frees;
    end
  end

  assign results.valid         = out_valid;
  assign results.status        = out_status;
  assign results.new_state     = out_state;
  assign results.started_seen  = out_started;
  assign results.is_terminated = out_term;
  assign results.source_kind   = out_source;
  assign results.takes_core    = out_takes;
  assign results.frees_core    = out_frees;

endmodule

FILE: hdl/tst_checker.sv
// Port-level checks for task_state_tracker_core, attached with bind.
// Depends on tst_pkg and the top level's channel interfaces.
module tst_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tst_pkg::StateW-1:0]    new_state,
  input logic                          started_seen,
  input logic                          is_terminated,
  input logic [tst_pkg::SourceW-1:0]   source_kind,
  input logic                          takes_core,
  input logic                          frees_core
);

  // a stalled result stays up
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // every input transfer shows a result on the next edge
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("no result after input transfer");

  a_term: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_terminated == (new_state == tst_pkg::SC_TERMINATED)))
    else $error("terminated flag disagrees with state");

  a_none: assert property (@(posedge clk) disable iff (rst)
    out_valid && (source_kind == tst_pkg::SRC_NONE) |-> !takes_core && !frees_core)
    else $error("unknown event claims a core action");

  // started flag is sticky between results
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && $past(out_valid) && !$past(rst) && $past(started_seen) |-> started_seen)
    else $error("started flag cleared");

endmodule

bind task_state_tracker_core tst_checker u_tst_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (events.valid),
  .in_ready      (events.ready),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .new_state     (results.new_state),
  .started_seen  (results.started_seen),
  .is_terminated (results.is_terminated),
  .source_kind   (results.source_kind),
  .takes_core    (results.takes_core),
  .frees_core    (results.frees_core)
);

FILE: test/task_state_tracker_core_tb.sv
// Self-checking testbench for task_state_tracker_core: trace events in, per-event results out.
// Depends on tst_pkg, the channel interfaces in hdl/tst_ifs.sv and the top-level RTL.
// Uses a scoreboard class with its own life-cycle predictor; random gaps on both channels.
module task_state_tracker_core_tb;
  import tst_pkg::*;

  localparam int MaxWait    = 6;     // longest sender gap / receiver stall in cycles
  localparam int PhaseItems = 118;   // random events per initial-state setting
  localparam int TailCycles = 8;     // window after the drain to catch stray results
  localparam int RunLimit   = 3_000_000;

  // Register offset of initial_state (index 0, 32-bit slots)
  localparam logic [ApbAddrW-1:0] InitStateAddr = '0;
  // Top raw event code; everything from EV_UNKNOWN up decodes as unknown
  localparam logic [EventW-1:0] RawCodeMax = '1;

  // One result as it leaves the tracker
  typedef struct packed {
    status_t     status;
    state_code_t new_state;
    logic        started_seen;
    logic        is_terminated;
    source_t     source_kind;
    logic        takes_core;
    logic        frees_core;
  } tracker_out_t;

  // Life-cycle predictor plus the queue of results still owed by the block.
  class life_cycle_scoreboard;
    state_code_t  life_state;
    logic         started;
    tracker_out_t pending_results[$];
    int           errors;
    int           events_seen;
    int           results_seen;
    int           refused;
    int           loads;

    function new();
      life_state   = SC_UNKNOWN;
      started      = 1'b0;
      errors       = 0;
      events_seen  = 0;
      results_seen = 0;
      refused      = 0;
      loads        = 0;
    endfunction

    function ev_code_t classify(logic [EventW-1:0] raw);
      if (raw >= EV_UNKNOWN) return EV_UNKNOWN;
      return ev_code_t'(raw);
    endfunction

    // Status of one event against state cur; nxt is the state if accepted.
    function status_t life_next(state_code_t cur, ev_code_t ev, output state_code_t nxt);
      nxt = cur;
      case (cur)
        SC_RUNNING: begin
          case (ev)
            EV_WAIT:                     nxt = SC_WAITING;
            EV_POLL:                     nxt = SC_POLLING;
            EV_PREEMPT:                  nxt = SC_READY;
            EV_TERMINATE:                nxt = SC_TERMINATED;
            EV_NOWAIT:                   nxt = SC_RUNNING;
            EV_START, EV_RESUME, EV_RUN: return STS_ALREADY;
            default:                     return STS_INVALID;
          endcase
        end
        SC_POLLING: begin
          case (ev)
            EV_RUN:                   nxt = SC_RUNNING;
            EV_PARK:                  nxt = SC_PARKING;
            EV_POLL_PARKING, EV_POLL: return STS_ALREADY;
            default:                  return STS_INVALID;
          endcase
        end
        SC_WAITING: begin
          case (ev)
            EV_RELEASE: nxt = SC_READY;
            EV_WAIT:    return STS_ALREADY;
            default:    return STS_INVALID;
          endcase
        end
        SC_PARKING: begin
          case (ev)
            EV_POLL_PARKING:    nxt = SC_POLLING;
            EV_RELEASE_PARKING: nxt = SC_READY;
            EV_PARK:            return STS_ALREADY;
            default:            return STS_INVALID;
          endcase
        end
        SC_READY: begin
          case (ev)
            EV_RESUME:                                 nxt = SC_RUNNING;
            EV_PREEMPT, EV_RELEASE, EV_RELEASE_PARKING: return STS_ALREADY;
            default:                                   return STS_INVALID;
          endcase
        end
        SC_ACTIVE: begin
          case (ev)
            EV_START:               nxt = SC_RUNNING;
            EV_INTERRUPT_SUSPENDED: nxt = SC_ACTIVE;
            EV_ACTIVATE:            return STS_ALREADY;
            default:                return STS_INVALID;
          endcase
        end
        SC_TERMINATED: begin
          case (ev)
            EV_ACTIVATE:  nxt = SC_ACTIVE;
            EV_MTA_LIMIT: nxt = SC_TERMINATED;
            EV_TERMINATE: return STS_ALREADY;
            default:      return STS_INVALID;
          endcase
        end
        default: begin
          // unknown state: listed events jump anywhere, the rest keep the state
          case (ev)
            EV_ACTIVATE, EV_MTA_LIMIT:                  nxt = SC_ACTIVE;
            EV_START, EV_RESUME, EV_RUN:                nxt = SC_RUNNING;
            EV_POLL, EV_POLL_PARKING:                   nxt = SC_POLLING;
            EV_PARK:                                    nxt = SC_PARKING;
            EV_RELEASE_PARKING, EV_PREEMPT, EV_RELEASE: nxt = SC_READY;
            EV_WAIT:                                    nxt = SC_WAITING;
            EV_TERMINATE:                               nxt = SC_TERMINATED;
            default:                                    nxt = cur;
          endcase
        end
      endcase
      return STS_OK;
    endfunction

    function source_t source_of(ev_code_t ev);
      if (ev == EV_ACTIVATE || ev == EV_MTA_LIMIT) return SRC_STIMULUS;
      if (ev == EV_INTERRUPT_SUSPENDED) return SRC_SCHEDULER;
      if (ev < EV_UNKNOWN) return SRC_CORE;
      return SRC_NONE;
    endfunction

    // Status the next event would get, without committing it
    function status_t peek(logic [EventW-1:0] raw);
      state_code_t nxt;
      return life_next(life_state, classify(raw), nxt);
    endfunction

    function void load_state(state_code_t code);
      life_state = code;
      loads++;
    endfunction

    function void note_event(logic [EventW-1:0] raw);
      ev_code_t     ev;
      state_code_t  nxt;
      tracker_out_t want;
      ev = classify(raw);
      want.status = life_next(life_state, ev, nxt);
      if (want.status == STS_OK) begin
        life_state = nxt;
        if (ev == EV_START) started = 1'b1;
      end else begin
        refused++;
      end
      want.new_state     = life_state;
      want.started_seen  = started;
      want.is_terminated = (life_state == SC_TERMINATED);
      want.source_kind   = source_of(ev);
      want.takes_core    = (ev == EV_POLL_PARKING || ev == EV_RESUME || ev == EV_START);
      want.frees_core    = (ev == EV_PARK || ev == EV_WAIT || ev == EV_TERMINATE ||
                            ev == EV_PREEMPT);
      pending_results.push_back(want);
      events_seen++;
    endfunction

    function void compare_field(string name, logic [3:0] want, logic [3:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(tracker_out_t got);
      tracker_out_t want;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing outstanding (new_state %0d)", got.new_state);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      results_seen++;
      compare_field("status",        4'(want.status),        4'(got.status));
      compare_field("new_state",     4'(want.new_state),     4'(got.new_state));
      compare_field("started_seen",  4'(want.started_seen),  4'(got.started_seen));
      compare_field("is_terminated", 4'(want.is_terminated), 4'(got.is_terminated));
      compare_field("source_kind",   4'(want.source_kind),   4'(got.source_kind));
      compare_field("takes_core",    4'(want.takes_core),    4'(got.takes_core));
      compare_field("frees_core",    4'(want.frees_core),    4'(got.frees_core));
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  tst_evt_if evt();
  tst_res_if res();

  task_state_tracker_core u_top (
    .clk     (clk),
    .rst     (rst),
    .events  (evt),
    .results (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  life_cycle_scoreboard sb = new();

  // Burst counters: while nonzero the side runs with no idle cycles at all
  int send_burst = 0;
  int recv_burst = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #RunLimit;
    $display("== FAIL ==");
    $finish;
  end

  // Per-transfer idle count: mostly 0..MaxWait, sometimes a zero-gap burst.
  function automatic int draw_wait(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, MaxWait);
  endfunction

  // Random event: mostly one the current state accepts, so the walk goes deep
  // through the life cycle; the rest is any raw code, unknown codes included.
  function automatic logic [EventW-1:0] pick_event();
    logic [EventW-1:0] code;
    if ($urandom_range(0, 9) < 7) begin
      do begin
        code = EventW'($urandom_range(EV_ACTIVATE, EV_NOWAIT));
      end while (sb.peek(code) != STS_OK);
    end else begin
      code = EventW'($urandom_range(0, RawCodeMax));
    end
    return code;
  endfunction

  // One event transfer. valid stays high across back-to-back items, so it is
  // only lowered when a gap is drawn.
  task automatic send_event(input logic [EventW-1:0] code);
    int gap;
    gap = draw_wait(send_burst);
    if (gap > 0) begin
      evt.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    evt.valid      <= 1'b1;
    evt.event_code <= code;
    @(posedge clk);
    while (evt.ready !== 1'b1) @(posedge clk);
    sb.note_event(code);
  endtask

  // Drop valid and wait until every owed result has been transferred.
  task automatic drain();
    evt.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; ends idle, with psel and penable low, so the next
  // access never reassigns psel in the same step.
  task automatic apb_access(input logic wr, input logic [ApbDataW-1:0] wdata,
                            output logic [ApbDataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= InitStateAddr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_initial_state(input state_code_t want);
    logic [ApbDataW-1:0] back;
    apb_access(1'b0, '0, back);
    if (back[StateW-1:0] !== want) begin
      $error("initial_state readback: expected %0d, got %0d", want, back[StateW-1:0]);
      sb.errors++;
    end
  endtask

  // Upper data bits are random junk; only the low state bits are kept.
  task automatic load_initial_state(input state_code_t code);
    logic [ApbDataW-1:0] unused;
    apb_access(1'b1, {(ApbDataW-StateW)'($urandom()), code}, unused);
    sb.load_state(code);
    read_initial_state(code);
  endtask

  // Result side: random stall before each transfer, then ready held high
  // until the block presents a result.
  initial begin : result_sink
    tracker_out_t got;
    int           stall;
    res.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = draw_wait(recv_burst);
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res.ready <= 1'b1;
      @(posedge clk);
      while (res.valid !== 1'b1) @(posedge clk);
      got.status        = status_t'(res.status);
      got.new_state     = state_code_t'(res.new_state);
      got.started_seen  = res.started_seen;
      got.is_terminated = res.is_terminated;
      got.source_kind   = source_t'(res.source_kind);
      got.takes_core    = res.takes_core;
      got.frees_core    = res.frees_core;
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    logic [EventW-1:0] directed_seq[$];
    state_code_t       state_plan[$];

    // Walk from the reset state: unknown and unlisted events in the unknown
    // state, mta limit out of unknown, refusals, then a tour of every state
    // with already-in-state events in all but polling, ending in active.
    directed_seq = '{EV_UNKNOWN, RawCodeMax, EV_FULL_MIGRATION, EV_NOWAIT,
                     EV_MTA_LIMIT, EV_ACTIVATE, EV_INTERRUPT_SUSPENDED, EV_UNKNOWN,
                     EV_START, EV_RUN, EV_NOWAIT, EV_POLL, EV_PARK, EV_PARK,
                     EV_POLL_PARKING, EV_RUN, EV_PREEMPT, EV_RELEASE, EV_RESUME,
                     EV_WAIT, EV_WAIT, EV_RELEASE, EV_RESUME, EV_TERMINATE,
                     EV_MTA_LIMIT, EV_TERMINATE, EV_ACTIVATE, EV_ENFORCED_MIGRATION};
    // Both extremes first, every state at least once, unknown at least twice
    state_plan = '{SC_RUNNING, SC_UNKNOWN, SC_TERMINATED, SC_PARKING, SC_ACTIVE,
                   SC_POLLING, SC_READY, SC_WAITING, SC_UNKNOWN,
                   state_code_t'($urandom_range(SC_RUNNING, SC_UNKNOWN)),
                   state_code_t'($urandom_range(SC_RUNNING, SC_UNKNOWN))};

    rst            <= 1'b1;
    evt.valid      <= 1'b0;
    evt.event_code <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    read_initial_state(SC_UNKNOWN);   // register reset value
    foreach (directed_seq[i]) send_event(directed_seq[i]);
    drain();

    // Every result is one per event, so an empty queue means the block is idle
    foreach (state_plan[p]) begin
      load_initial_state(state_plan[p]);
      repeat (PhaseItems) send_event(pick_event());
      drain();
    end

    repeat (TailCycles) @(posedge clk);

    $display("Ran %0d trace events (%0d refused) across %0d initial-state loads;",
             sb.events_seen, sb.refused, sb.loads);
    $display("compared %0d results field by field, %0d mismatches.",
             sb.results_seen, sb.errors);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/tst_pkg.sv
hdl/tst_ifs.sv
hdl/task_state_tracker_core.sv
hdl/tst_checker.sv
test/task_state_tracker_core_tb.sv
